/* rtl/teq_pkg.sv */
// Shared types, constants and helpers of the timed event queue.
`timescale 1ns / 1ps
package teq_pkg;

   localparam int CAPACITY    = 32;
   localparam int DEVICE_BITS = 6;
   localparam int MAX_RESULTS = 32;

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int BUF_W  = $clog2(MAX_RESULTS);
   localparam int NUM_W  = $clog2(MAX_RESULTS + 1);

   localparam logic [1:0] CMD_INSERT   = 2'd0;
   localparam logic [1:0] CMD_DISPATCH = 2'd1;
   localparam logic [1:0] CMD_FLUSH    = 2'd2;
   localparam logic [1:0] CMD_DISCARD  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_BURST = 2'd2;

   localparam logic [5:0] BURST_RESET = 6'd32;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] at_time;
      logic [5:0]  device_id;
      logic [7:0]  reason_code;
   } req_type;

   typedef struct packed {
      logic        event_valid;
      logic [5:0]  out_device;
      logic [7:0]  out_reason;
      logic [63:0] out_time;
      logic        last;
      logic [1:0]  status;
      logic        any_dispatched;
      logic        head_valid;
      logic [63:0] head_time;
   } rsp_type;

   typedef struct packed {
      logic [63:0]            time_val;
      logic [DEVICE_BITS-1:0] device;
      logic [7:0]             reason;
   } entry_type;

   // Physical slot of the entry that sits off places behind the head.
   function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] head,
                                                    input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(CAPACITY)) begin
         sum = sum - (CNT_W+1)'(CAPACITY);
      end
      return ADDR_W'(sum);
   endfunction

endpackage

/* rtl/timed_event_queue_unit.sv */
// Top level of the timed event queue: sequencer around an entry RAM and a result RAM.
`timescale 1ns / 1ps
// The queue keeps up to CAPACITY events in time order in a ring held in a RAM.
// One command item enters on the req_ channel (valid/ready) and yields one or
// more result items on the rsp_ channel; the final one has last set. The
// csr_ port writes the burst limit; the user must write it only while the block
// idles, as the block itself does not enforce this. Each item is worked on alone:
// req_ready is high only while the block idles. Insert walks the ring from the
// tail, reading each entry and moving each later one a place toward the tail,
// then writes the new entry. Dispatch and flush pop entries from the head into
// a result RAM, then read the head time back; each result is then read from the
// result RAM before it is shown, as both RAMs have a registered read port. A
// result waits in the output register while rsp_ready is low, and the block
// holds everything else until it is taken.
// Reset empties the queue, sets the burst limit to 32 and drops any result in
// flight; RAM contents are not cleared since only entries below the count are
// ever read.
module timed_event_queue_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  teq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output teq_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_INS_RD    = 4'd1;
   localparam logic [3:0] S_INS_CMP   = 4'd2;
   localparam logic [3:0] S_INS_WR    = 4'd3;
   localparam logic [3:0] S_POP_RD    = 4'd4;
   localparam logic [3:0] S_POP_CMP   = 4'd5;
   localparam logic [3:0] S_FIN_RD    = 4'd6;
   localparam logic [3:0] S_FIN       = 4'd7;
   localparam logic [3:0] S_EMIT_LD   = 4'd8;
   localparam logic [3:0] S_EMIT_WAIT = 4'd9;

   logic [3:0]                  state_ff, state_in;
   logic [5:0]                  max_burst_ff;
   teq_pkg::req_type            cmd_ff, cmd_in;
   logic [teq_pkg::ADDR_W-1:0]  head_ff, head_in;
   logic [teq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [teq_pkg::CNT_W-1:0]   pos_ff, pos_in;
   logic [teq_pkg::NUM_W-1:0]   num_ff, num_in;
   logic [teq_pkg::BUF_W-1:0]   idx_ff, idx_in;
   logic [teq_pkg::NUM_W-1:0]   group_ff, group_in;
   logic [63:0]                 group_time_ff, group_time_in;
   logic [1:0]                  status_ff, status_in;
   logic                        head_valid_ff, head_valid_in;
   logic [63:0]                 head_time_ff, head_time_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   teq_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        ent_we, ent_re;
   logic [teq_pkg::ADDR_W-1:0]  ent_wa, ent_ra;
   teq_pkg::entry_type          ent_wd, ent_rd;
   logic                        buf_we, buf_re;
   logic [teq_pkg::BUF_W-1:0]   buf_wa, buf_ra;
   teq_pkg::entry_type          buf_rd;

   logic [teq_pkg::NUM_W-1:0]   limit;
   logic [teq_pkg::NUM_W-1:0]   group_cur;
   logic                        new_group;
   logic                        is_last;

   teq_ram #(.WIDTH($bits(teq_pkg::entry_type)), .DEPTH(teq_pkg::CAPACITY)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_wa),
      .wr_data (ent_wd),
      .rd_en   (ent_re),
      .rd_addr (ent_ra),
      .rd_data (ent_rd)
   );

   teq_ram #(.WIDTH($bits(teq_pkg::entry_type)), .DEPTH(teq_pkg::MAX_RESULTS)) u_result_ram (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_wa),
      .wr_data (ent_rd),
      .rd_en   (buf_re),
      .rd_addr (buf_ra),
      .rd_data (buf_rd)
   );

   // A limit of zero acts as one; anything above the result bound is clipped.
   always_comb begin
      if (max_burst_ff == 6'd0) begin
         limit = teq_pkg::NUM_W'(1);
      end else if (32'(max_burst_ff) > teq_pkg::MAX_RESULTS) begin
         limit = teq_pkg::NUM_W'(teq_pkg::MAX_RESULTS);
      end else begin
         limit = teq_pkg::NUM_W'(max_burst_ff);
      end
   end

   assign new_group = (num_ff == '0) || (ent_rd.time_val != group_time_ff);
   assign group_cur = new_group ? '0 : group_ff;
   assign is_last   = (teq_pkg::NUM_W'(idx_ff) + teq_pkg::NUM_W'(1)) == num_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      num_in        = num_ff;
      idx_in        = idx_ff;
      group_in      = group_ff;
      group_time_in = group_time_ff;
      status_in     = status_ff;
      head_valid_in = head_valid_ff;
      head_time_in  = head_time_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      ent_we        = 1'b0;
      ent_wa        = teq_pkg::phys_addr(head_ff, pos_ff);
      ent_wd        = ent_rd;
      ent_re        = 1'b0;
      ent_ra        = teq_pkg::phys_addr(head_ff, '0);
      buf_we        = 1'b0;
      buf_wa        = teq_pkg::BUF_W'(num_ff);
      buf_re        = 1'b0;
      buf_ra        = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_data;
               num_in    = '0;
               idx_in    = '0;
               group_in  = '0;
               status_in = teq_pkg::ST_OK;
               pos_in    = count_ff;
               unique case (req_data.command)
                  teq_pkg::CMD_INSERT: begin
                     if (32'(count_ff) >= teq_pkg::CAPACITY) begin
                        status_in = teq_pkg::ST_FULL;
                        state_in  = S_FIN_RD;
                     end else if (count_ff == '0) begin
                        state_in = S_INS_WR;
                     end else begin
                        state_in = S_INS_RD;
                     end
                  end
                  teq_pkg::CMD_DISPATCH, teq_pkg::CMD_FLUSH: begin
                     state_in = S_POP_RD;
                  end
                  default: begin
                     count_in = '0;
                     state_in = S_FIN_RD;
                  end
               endcase
            end
         end
         S_INS_RD: begin
            ent_re   = 1'b1;
            ent_ra   = teq_pkg::phys_addr(head_ff, pos_ff - teq_pkg::CNT_W'(1));
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            // A later entry moves one place toward the tail; equal times stay ahead.
            if (ent_rd.time_val > cmd_ff.at_time) begin
               ent_we   = 1'b1;
               pos_in   = pos_ff - teq_pkg::CNT_W'(1);
               state_in = (pos_ff == teq_pkg::CNT_W'(1)) ? S_INS_WR : S_INS_RD;
            end else begin
               state_in = S_INS_WR;
            end
         end
         S_INS_WR: begin
            ent_we          = 1'b1;
            ent_wd.time_val = cmd_ff.at_time;
            ent_wd.device   = teq_pkg::DEVICE_BITS'(cmd_ff.device_id);
            ent_wd.reason   = cmd_ff.reason_code;
            count_in        = count_ff + teq_pkg::CNT_W'(1);
            state_in        = S_FIN_RD;
         end
         S_POP_RD: begin
            if (count_ff == '0 || 32'(num_ff) >= teq_pkg::MAX_RESULTS) begin
               state_in = S_FIN_RD;
            end else begin
               ent_re   = 1'b1;
               state_in = S_POP_CMP;
            end
         end
         S_POP_CMP: begin
            state_in = S_POP_RD;
            if (cmd_ff.command == teq_pkg::CMD_DISPATCH) begin
               if (ent_rd.time_val > cmd_ff.at_time) begin
                  state_in = S_FIN_RD;
               end else if (num_ff == limit) begin
                  status_in = teq_pkg::ST_BURST;
                  state_in  = S_FIN_RD;
               end else begin
                  buf_we = 1'b1;
               end
            end else begin
               if (group_cur == limit) begin
                  status_in = teq_pkg::ST_BURST;
                  state_in  = S_FIN_RD;
               end else begin
                  buf_we        = 1'b1;
                  group_in      = group_cur + teq_pkg::NUM_W'(1);
                  group_time_in = ent_rd.time_val;
               end
            end
            if (buf_we) begin
               head_in  = teq_pkg::phys_addr(head_ff, teq_pkg::CNT_W'(1));
               count_in = count_ff - teq_pkg::CNT_W'(1);
               num_in   = num_ff + teq_pkg::NUM_W'(1);
            end
         end
         S_FIN_RD: begin
            ent_re   = 1'b1;
            state_in = S_FIN;
         end
         S_FIN: begin
            head_valid_in = (count_ff != '0);
            head_time_in  = (count_ff != '0) ? ent_rd.time_val : 64'd0;
            if (num_ff == '0) begin
               rsp_in                = '0;
               rsp_in.last           = 1'b1;
               rsp_in.status         = status_ff;
               rsp_in.head_valid     = (count_ff != '0);
               rsp_in.head_time      = (count_ff != '0) ? ent_rd.time_val : 64'd0;
               rsp_valid_in          = 1'b1;
               state_in              = S_EMIT_WAIT;
            end else begin
               buf_re   = 1'b1;
               state_in = S_EMIT_LD;
            end
         end
         S_EMIT_LD: begin
            rsp_in.event_valid    = 1'b1;
            rsp_in.out_device     = 6'(buf_rd.device);
            rsp_in.out_reason     = buf_rd.reason;
            rsp_in.out_time       = buf_rd.time_val;
            rsp_in.last           = is_last;
            rsp_in.status         = is_last ? status_ff : teq_pkg::ST_OK;
            rsp_in.any_dispatched = 1'b1;
            rsp_in.head_valid     = head_valid_ff;
            rsp_in.head_time      = head_time_ff;
            rsp_valid_in          = 1'b1;
            state_in              = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + teq_pkg::BUF_W'(1);
                  buf_re   = 1'b1;
                  buf_ra   = idx_ff + teq_pkg::BUF_W'(1);
                  state_in = S_EMIT_LD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_burst_ff <= teq_pkg::BURST_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_burst_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      num_ff        <= num_in;
      idx_ff        <= idx_in;
      group_ff      <= group_in;
      group_time_ff <= group_time_in;
      status_ff     <= status_in;
      head_valid_ff <= head_valid_in;
      head_time_ff  <= head_time_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= teq_pkg::CAPACITY)
      else $error("entry count beyond capacity");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new item taken while a result is pending");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != teq_pkg::ST_OK) |-> rsp_data.last)
      else $error("status reported on a result that is not the last");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.event_valid) |-> (rsp_data.last && !rsp_data.any_dispatched))
      else $error("result without event is not the only one");

endmodule

/* rtl/teq_ram.sv */
// Simple dual port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module teq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
